// ===== rtl/core/pbw_pkg.sv =====
// Shared types and constants for the pinhole back-projection pipeline.
package pbw_pkg;

	localparam int WORD_W     = 32;
	localparam int SLOT_W     = 4;
	localparam int PIX_W      = 20;
	localparam int IDEP_W     = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int POSE_WORDS = 12;
	localparam int ROT_WORDS  = 9;

	// Datapath widths, sized from the value ranges of each quantity.
	localparam int RAY_W   = 30;
	localparam int DEPTH_W = 33;
	localparam int CAM_W   = 47;
	localparam int CH_W    = 31;
	localparam int CL_W    = 16;

	// Reciprocal unit: four quotient bits per stage over a 36-bit numerator.
	localparam int RECIP_STAGES = 9;
	localparam int RECIP_BITS   = 4;
	localparam int NUM_W        = RECIP_STAGES * RECIP_BITS;

	localparam logic ACT_POINT = 1'b1;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_SAT        = 2'd1,
		ST_ZERO_DEPTH = 2'd2,
		ST_NONFINAL   = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INV_FX = 2'd0,
		CFG_INV_FY = 2'd1,
		CFG_OFF_X  = 2'd2,
		CFG_OFF_Y  = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic                     is_point;
		logic                     nonfinal;
		logic                     zero;
		logic [SLOT_W-1:0]        slot;
		logic signed [WORD_W-1:0] word;
		logic [PIX_W-1:0]         u;
		logic [PIX_W-1:0]         v;
		logic [IDEP_W-1:0]        idep;
	} side_t;

	typedef struct packed {
		logic                     en;
		logic [SLOT_W-1:0]        slot;
		logic signed [WORD_W-1:0] word;
	} pose_wr_t;

	typedef struct packed {
		logic nonfinal;
		logic zero;
	} flags_t;

endpackage

// ===== rtl/core/pbw_if.sv =====
// Request channel interfaces for point input and world point output.
interface pbw_in_if import pbw_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     action;
	logic [SLOT_W-1:0]        pose_slot;
	logic signed [WORD_W-1:0] pose_word;
	logic [PIX_W-1:0]         pixel_u;
	logic [PIX_W-1:0]         pixel_v;
	logic [IDEP_W-1:0]        inverse_depth;
	logic                     final_frame;

	modport source (output valid, action, pose_slot, pose_word, pixel_u, pixel_v,
		inverse_depth, final_frame, input ready);
	modport sink (input valid, action, pose_slot, pose_word, pixel_u, pixel_v,
		inverse_depth, final_frame, output ready);
endinterface

interface pbw_out_if import pbw_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [WORD_W-1:0] world_x;
	logic signed [WORD_W-1:0] world_y;
	logic signed [WORD_W-1:0] world_z;
	logic [1:0]               status;

	modport source (output valid, world_x, world_y, world_z, status, input ready);
	modport sink (input valid, world_x, world_y, world_z, status, output ready);
endinterface

// ===== rtl/core/pbw_recip.sv =====
// Pipelined restoring divider that forms the rounded depth 2^32 / inverse depth.
module pbw_recip import pbw_pkg::*; (
	input  logic                    clk,
	input  logic [RECIP_STAGES-1:0] adv,
	input  logic [IDEP_W-1:0]       idep,
	output logic [DEPTH_W-1:0]      depth
);

	localparam logic [NUM_W-1:0] NUM_ONE = NUM_W'(1) << 32;

	logic [IDEP_W-1:0] rem_s [RECIP_STAGES];
	logic [IDEP_W-1:0] den_s [RECIP_STAGES];
	logic [NUM_W-1:0]  nq_s  [RECIP_STAGES];

	for (genvar k = 0; k < RECIP_STAGES; k++) begin : g_stage
		logic [IDEP_W-1:0] rem_i, den_i, rem_o;
		logic [NUM_W-1:0]  nq_i, nq_o;

		if (k == 0) begin : g_first
			// Rounding is folded in by adding half the divisor to the numerator.
			assign rem_i = '0;
			assign den_i = idep;
			assign nq_i  = NUM_ONE + NUM_W'(idep >> 1);
		end else begin : g_next
			assign rem_i = rem_s[k-1];
			assign den_i = den_s[k-1];
			assign nq_i  = nq_s[k-1];
		end

		always_comb begin
			logic [IDEP_W:0] t;
			rem_o = rem_i;
			nq_o  = nq_i;
			for (int b = 0; b < RECIP_BITS; b++) begin
				t    = {rem_o, nq_o[NUM_W-1]};
				nq_o = {nq_o[NUM_W-2:0], 1'b0};
				if (t >= {1'b0, den_i}) begin
					t       = t - {1'b0, den_i};
					nq_o[0] = 1'b1;
				end
				rem_o = t[IDEP_W-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k]) begin
				rem_s[k] <= rem_o;
				den_s[k] <= den_i;
				nq_s[k]  <= nq_o;
			end
		end
	end

	assign depth = nq_s[RECIP_STAGES-1][DEPTH_W-1:0];

endmodule

// ===== rtl/core/pbw_ray.sv =====
// Two-stage ray component: pixel times inverse focal length plus offset, rounded.
module pbw_ray import pbw_pkg::*; (
	input  logic                     clk,
	input  logic [1:0]               adv,
	input  logic [PIX_W-1:0]         pix,
	input  logic [WORD_W-1:0]        inv_focal,
	input  logic signed [WORD_W-1:0] offset,
	output logic signed [RAY_W-1:0]  ray
);

	localparam int PROD_W = PIX_W + WORD_W;
	localparam int SUM_W  = PROD_W + 2;

	logic [PROD_W-1:0]       prod_s9;
	logic signed [RAY_W-1:0] ray_s10;
	logic signed [SUM_W-1:0] sum;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			prod_s9 <= PROD_W'(pix) * PROD_W'(inv_focal);
		end
	end

	// Offset is Q4.28; it lines up with the product after a shift by twelve.
	assign sum = $signed({2'b00, prod_s9}) + (SUM_W'(offset) <<< 12) + SUM_W'(1 << 23);

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			ray_s10 <= sum[SUM_W-1:24];
		end
	end

	assign ray = ray_s10;

endmodule

// ===== rtl/core/pbw_cam.sv =====
// Two-stage scaling of a ray component by depth into a camera-space coordinate.
module pbw_cam import pbw_pkg::*; (
	input  logic                    clk,
	input  logic [1:0]              adv,
	input  logic signed [RAY_W-1:0] ray,
	input  logic [DEPTH_W-1:0]      depth,
	output logic signed [CH_W-1:0]  ch,
	output logic [CL_W-1:0]         cl
);

	localparam int PH_W = CAM_W;
	localparam int PL_W = CAM_W - 1;

	logic signed [PH_W-1:0]  ph_s11;
	logic signed [PL_W-1:0]  pl_s11;
	logic signed [CAM_W-1:0] cam_s12;

	// Depth is split at the binary point so each product stays narrow.
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			ph_s11 <= PH_W'(ray) * PH_W'($signed({1'b0, depth[DEPTH_W-1:16]}));
			pl_s11 <= PL_W'(ray) * PL_W'($signed({1'b0, depth[15:0]}));
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			cam_s12 <= ph_s11 + CAM_W'((pl_s11 + PL_W'(32768)) >>> 16);
		end
	end

	assign ch = cam_s12[CAM_W-1:16];
	assign cl = cam_s12[CL_W-1:0];

endmodule

// ===== rtl/core/pbw_xform.sv =====
// Pose store and four-stage rigid transform with rounding and saturation.
module pbw_xform import pbw_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [3:0]               adv,
	input  pose_wr_t                 wr,
	input  flags_t                   flags,
	input  logic signed [CH_W-1:0]   ch_x,
	input  logic signed [CH_W-1:0]   ch_y,
	input  logic [CL_W-1:0]          cl_x,
	input  logic [CL_W-1:0]          cl_y,
	input  logic [DEPTH_W-1:0]       depth,
	output logic signed [WORD_W-1:0] world_x,
	output logic signed [WORD_W-1:0] world_y,
	output logic signed [WORD_W-1:0] world_z,
	output status_t                  status
);

	localparam int PRH_W  = WORD_W + CH_W;
	localparam int PRL_W  = WORD_W + CL_W + 1;
	localparam int SH_W   = PRH_W + 1;
	localparam int SL_W   = PRL_W + 2;
	localparam int Q_W    = SH_W - 14;
	localparam int REST_W = SL_W + 1;
	localparam int W_W    = REST_W;
	localparam logic signed [WORD_W-1:0] I32_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic signed [WORD_W-1:0] I32_MIN = {1'b1, {(WORD_W-1){1'b0}}};

	logic signed [WORD_W-1:0] pose_q [POSE_WORDS];

	logic signed [CH_W-1:0] ch [3];
	logic [CL_W-1:0]        cl [3];

	logic signed [PRH_W-1:0]  ph_s13 [3][3];
	logic signed [PRL_W-1:0]  pl_s13 [3][3];
	logic signed [WORD_W-1:0] t_s13  [3];
	flags_t                   flags_s13;

	logic signed [SH_W-1:0]   sh_s14 [3];
	logic signed [SL_W-1:0]   sl_s14 [3];
	logic signed [WORD_W-1:0] t_s14  [3];
	flags_t                   flags_s14;

	logic signed [Q_W-1:0]    q_s15    [3];
	logic signed [REST_W-1:0] rest_s15 [3];
	logic signed [WORD_W-1:0] t_s15    [3];
	flags_t                   flags_s15;

	logic signed [WORD_W-1:0] world_s16 [3];
	status_t                  status_s16;

	logic signed [W_W-1:0]    w     [3];
	logic signed [WORD_W-1:0] w_sat [3];
	logic                     sat_any;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < POSE_WORDS; i++) pose_q[i] <= '0;
		end else if (wr.en && (wr.slot < SLOT_W'(POSE_WORDS))) begin
			pose_q[wr.slot] <= wr.word;
		end
	end

	assign ch[0] = ch_x;
	assign ch[1] = ch_y;
	assign ch[2] = $signed({{(CH_W-DEPTH_W+16){1'b0}}, depth[DEPTH_W-1:16]});
	assign cl[0] = cl_x;
	assign cl[1] = cl_y;
	assign cl[2] = depth[CL_W-1:0];

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			for (int r = 0; r < 3; r++) begin
				for (int j = 0; j < 3; j++) begin
					ph_s13[r][j] <= PRH_W'(pose_q[r*3+j]) * PRH_W'(ch[j]);
					pl_s13[r][j] <= PRL_W'(pose_q[r*3+j]) * PRL_W'($signed({1'b0, cl[j]}));
				end
				t_s13[r] <= pose_q[ROT_WORDS+r];
			end
			flags_s13 <= flags;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			for (int r = 0; r < 3; r++) begin
				sh_s14[r] <= SH_W'(ph_s13[r][0]) + SH_W'(ph_s13[r][1]) + SH_W'(ph_s13[r][2]);
				sl_s14[r] <= SL_W'(pl_s13[r][0]) + SL_W'(pl_s13[r][1]) + SL_W'(pl_s13[r][2]);
				t_s14[r]  <= t_s13[r];
			end
			flags_s14 <= flags_s13;
		end
	end

	// The high sum is split so the low part joins the low sum before rounding.
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			for (int r = 0; r < 3; r++) begin
				q_s15[r]    <= sh_s14[r][SH_W-1:14];
				rest_s15[r] <= REST_W'($signed({1'b0, sh_s14[r][13:0], 16'b0}))
					+ REST_W'(sl_s14[r]) + REST_W'(1 << 29);
				t_s15[r]    <= t_s14[r];
			end
			flags_s15 <= flags_s14;
		end
	end

	always_comb begin
		sat_any = 1'b0;
		for (int r = 0; r < 3; r++) begin
			w[r] = W_W'(q_s15[r]) + W_W'(rest_s15[r] >>> 30) + W_W'(t_s15[r]);
			if (w[r] > W_W'(I32_MAX)) begin
				w_sat[r] = I32_MAX;
				sat_any  = 1'b1;
			end else if (w[r] < W_W'(I32_MIN)) begin
				w_sat[r] = I32_MIN;
				sat_any  = 1'b1;
			end else begin
				w_sat[r] = w[r][WORD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			priority if (flags_s15.nonfinal) begin
				status_s16 <= ST_NONFINAL;
				for (int r = 0; r < 3; r++) world_s16[r] <= '0;
			end else if (flags_s15.zero) begin
				status_s16 <= ST_ZERO_DEPTH;
				for (int r = 0; r < 3; r++) world_s16[r] <= '0;
			end else begin
				status_s16 <= sat_any ? ST_SAT : ST_OK;
				for (int r = 0; r < 3; r++) world_s16[r] <= w_sat[r];
			end
		end
	end

	assign world_x = world_s16[0];
	assign world_y = world_s16[1];
	assign world_z = world_s16[2];
	assign status  = status_s16;

endmodule

// ===== rtl/core/pinhole_backproject_to_world.sv =====
// Top level of the pinhole back-projection pipeline with its valid chain.
//
// Software first writes the four camera registers through the write port
// (cfg_we, cfg_index, cfg_data): inverse focal lengths and principal point
// offsets. Requests then arrive on the ingress channel. A request with
// action zero writes one word of the camera-to-world pose and gives no
// result; a request with action one turns a pixel and its inverse depth
// into a world point, delivered on the egress channel with a status code.
//
// The pipeline is sixteen register stages deep. A new request is taken every
// cycle unless a stall on egress has filled every stage back to the input.
// The depth is set by the input register, the pipelined divider for the
// reciprocal (nine stages, four quotient bits each), the two-stage depth
// multiply and the four-stage rotate, round and saturate path.
// Pose writes take effect in order with points, at the rotation stage.
//
// Reset clears the camera registers, the pose store and every valid bit.
// When the receiver holds ready low, the last stage holds its result and
// stages behind it keep filling until they meet a held stage, so empty
// slots are squeezed out and nothing is dropped or repeated.
module pinhole_backproject_to_world import pbw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	pbw_in_if.sink               ingress,
	pbw_out_if.source            egress
);

	localparam int STAGES = 16;

	logic [WORD_W-1:0]        inv_fx_q, inv_fy_q;
	logic signed [WORD_W-1:0] off_x_q, off_y_q;

	logic [STAGES:1]   vld_s;
	logic [STAGES+1:1] adv;
	side_t             side_s [1:12];

	logic [DEPTH_W-1:0]      depth_s10, depth_s11, depth_s12;
	logic signed [RAY_W-1:0] ray_x, ray_y;
	logic signed [CH_W-1:0]  ch_x, ch_y;
	logic [CL_W-1:0]         cl_x, cl_y;
	pose_wr_t                pose_wr;
	flags_t                  flags;
	status_t                 status;

	// Software must write these registers only while the pipeline is empty; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_fx_q <= '0;
			inv_fy_q <= '0;
			off_x_q  <= '0;
			off_y_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_INV_FX: inv_fx_q <= cfg_data;
				CFG_INV_FY: inv_fy_q <= cfg_data;
				CFG_OFF_X:  off_x_q  <= cfg_data;
				CFG_OFF_Y:  off_y_q  <= cfg_data;
			endcase
		end
	end

	// A stage may load when it is empty or when the stage after it moves.
	always_comb begin
		adv[STAGES+1] = egress.ready;
		for (int k = STAGES; k >= 1; k--) begin
			adv[k] = !vld_s[k] || adv[k+1];
		end
	end

	assign ingress.ready = adv[1];

	// Pose writes leave the pipeline at the rotation stage, where they are written into the pose store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 1; k <= STAGES; k++) begin
				if (adv[k]) begin
					if (k == 1) vld_s[k] <= ingress.valid;
					else if (k == 13) vld_s[k] <= vld_s[12] && side_s[12].is_point;
					else vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			side_s[1].is_point <= (ingress.action == ACT_POINT);
			side_s[1].nonfinal <= !ingress.final_frame;
			side_s[1].zero     <= (ingress.inverse_depth == '0);
			side_s[1].slot     <= ingress.pose_slot;
			side_s[1].word     <= ingress.pose_word;
			side_s[1].u        <= ingress.pixel_u;
			side_s[1].v        <= ingress.pixel_v;
			side_s[1].idep     <= ingress.inverse_depth;
		end
		for (int k = 2; k <= 12; k++) begin
			if (adv[k]) side_s[k] <= side_s[k-1];
		end
		if (adv[11]) depth_s11 <= depth_s10;
		if (adv[12]) depth_s12 <= depth_s11;
	end

	pbw_recip u_recip (
		.clk   (clk),
		.adv   (adv[10:2]),
		.idep  (side_s[1].idep),
		.depth (depth_s10)
	);

	pbw_ray u_ray_x (
		.clk       (clk),
		.adv       (adv[10:9]),
		.pix       (side_s[8].u),
		.inv_focal (inv_fx_q),
		.offset    (off_x_q),
		.ray       (ray_x)
	);

	pbw_ray u_ray_y (
		.clk       (clk),
		.adv       (adv[10:9]),
		.pix       (side_s[8].v),
		.inv_focal (inv_fy_q),
		.offset    (off_y_q),
		.ray       (ray_y)
	);

	pbw_cam u_cam_x (
		.clk   (clk),
		.adv   (adv[12:11]),
		.ray   (ray_x),
		.depth (depth_s10),
		.ch    (ch_x),
		.cl    (cl_x)
	);

	pbw_cam u_cam_y (
		.clk   (clk),
		.adv   (adv[12:11]),
		.ray   (ray_y),
		.depth (depth_s10),
		.ch    (ch_y),
		.cl    (cl_y)
	);

	assign pose_wr.en   = adv[13] && vld_s[12] && !side_s[12].is_point;
	assign pose_wr.slot = side_s[12].slot;
	assign pose_wr.word = side_s[12].word;

	assign flags.nonfinal = side_s[12].nonfinal;
	assign flags.zero     = side_s[12].zero;

	pbw_xform u_xform (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv[16:13]),
		.wr      (pose_wr),
		.flags   (flags),
		.ch_x    (ch_x),
		.ch_y    (ch_y),
		.cl_x    (cl_x),
		.cl_y    (cl_y),
		.depth   (depth_s12),
		.world_x (egress.world_x),
		.world_y (egress.world_y),
		.world_z (egress.world_z),
		.status  (status)
	);

	assign egress.status = status;
	assign egress.valid  = vld_s[STAGES];

endmodule

// ===== rtl/core/pbw_checker.sv =====
// Port-level checks for the back-projection block and their bind.
module pbw_checker import pbw_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_ready,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic signed [WORD_W-1:0] world_x,
	input logic signed [WORD_W-1:0] world_y,
	input logic signed [WORD_W-1:0] world_z,
	input logic [1:0]               status
);

	localparam logic signed [WORD_W-1:0] I32_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic signed [WORD_W-1:0] I32_MIN = {1'b1, {(WORD_W-1){1'b0}}};

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(world_x) && $stable(world_y)
			&& $stable(world_z) && $stable(status))
		else $error("result changed while stalled");

	a_zero_on_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_ZERO_DEPTH || status == ST_NONFINAL)
			|-> world_x == '0 && world_y == '0 && world_z == '0)
		else $error("rejected point carries a nonzero coordinate");

	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_SAT |-> world_x == I32_MAX || world_x == I32_MIN
			|| world_y == I32_MAX || world_y == I32_MIN
			|| world_z == I32_MAX || world_z == I32_MIN)
		else $error("saturation flagged with no coordinate at a bound");

	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input stalled while the output side can move");

endmodule

bind pinhole_backproject_to_world pbw_checker u_pbw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (ingress.ready),
	.out_valid (egress.valid),
	.out_ready (egress.ready),
	.world_x   (egress.world_x),
	.world_y   (egress.world_y),
	.world_z   (egress.world_z),
	.status    (egress.status)
);

// ===== test/tb_pinhole_backproject_to_world.sv =====
// Self-checking testbench for the pinhole back-projection pipeline.
`timescale 1ns / 100ps

module tb_pinhole_backproject_to_world;
	import pbw_pkg::*;

	// Action code for a pose word write; the package names only the point action.
	localparam logic ACT_LOAD = ~ACT_POINT;
	// Longest time the pipeline may keep working after the last result, in cycles.
	localparam int DRAIN_CYCLES = 24;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int MAX_GAP      = 17;

	typedef struct {
		logic                     action;
		logic [SLOT_W-1:0]        slot;
		logic signed [WORD_W-1:0] word;
		logic [PIX_W-1:0]         u;
		logic [PIX_W-1:0]         v;
		logic [IDEP_W-1:0]        idep;
		logic                     fin;
	} request_t;

	typedef struct {
		logic signed [WORD_W-1:0] x;
		logic signed [WORD_W-1:0] y;
		logic signed [WORD_W-1:0] z;
		logic [1:0]               status;
	} world_pt_t;

	// Keeps a private copy of the camera registers and the pose, predicts the
	// world point for every accepted point request and checks results in order.
	class world_point_board;
		logic [WORD_W-1:0]        inv_fx, inv_fy;
		logic signed [WORD_W-1:0] off_x, off_y;
		logic signed [WORD_W-1:0] pose [POSE_WORDS];
		world_pt_t                awaited [$];
		int                       mismatches;
		int                       points_checked;

		function void clear_state();
			inv_fx = '0;
			inv_fy = '0;
			off_x = '0;
			off_y = '0;
			foreach (pose[i]) pose[i] = '0;
			awaited.delete();
			mismatches = 0;
			points_checked = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [WORD_W-1:0] val);
			case (idx)
				CFG_INV_FX: inv_fx = val;
				CFG_INV_FY: inv_fy = val;
				CFG_OFF_X:  off_x = val;
				CFG_OFF_Y:  off_y = val;
				default: ;
			endcase
		endfunction

		function world_pt_t backproject(request_t r);
			logic signed [127:0] px, py, fx, fy, ox, oy, depth, ray_x, ray_y, acc, w;
			logic signed [127:0] cam [3];
			logic signed [127:0] rot, tr;
			world_pt_t res;
			bit sat;
			res.x = '0;
			res.y = '0;
			res.z = '0;
			sat = 0;
			if (!r.fin) begin
				res.status = ST_NONFINAL;
				return res;
			end
			if (r.idep == 0) begin
				res.status = ST_ZERO_DEPTH;
				return res;
			end
			px = r.u;
			py = r.v;
			fx = inv_fx;
			fy = inv_fy;
			ox = off_x;
			oy = off_y;
			depth = ((128'sd1 <<< 32) + (r.idep >> 1)) / r.idep;
			ray_x = (px * fx + ox * 4096 + (128'sd1 <<< 23)) >>> 24;
			ray_y = (py * fy + oy * 4096 + (128'sd1 <<< 23)) >>> 24;
			cam[0] = (ray_x * depth + 32768) >>> 16;
			cam[1] = (ray_y * depth + 32768) >>> 16;
			cam[2] = depth;
			for (int k = 0; k < 3; k++) begin
				acc = 0;
				for (int j = 0; j < 3; j++) begin
					rot = pose[k * 3 + j];
					acc = acc + rot * cam[j];
				end
				tr = pose[9 + k];
				w = ((acc + (128'sd1 <<< 29)) >>> 30) + tr;
				if (w > 128'sd2147483647) begin
					sat = 1;
					w = 128'sd2147483647;
				end else if (w < -128'sd2147483648) begin
					sat = 1;
					w = -128'sd2147483648;
				end
				case (k)
					0: res.x = w[31:0];
					1: res.y = w[31:0];
					default: res.z = w[31:0];
				endcase
			end
			res.status = sat ? ST_SAT : ST_OK;
			return res;
		endfunction

		function void note_request(request_t r);
			if (r.action == ACT_LOAD) begin
				if (r.slot < POSE_WORDS) pose[r.slot] = r.word;
			end else begin
				awaited.insert(awaited.size(), backproject(r));
			end
		endfunction

		function void check_result(world_pt_t got);
			world_pt_t exp;
			points_checked++;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result with nothing awaited: x=%0d y=%0d z=%0d st=%0d",
						got.x, got.y, got.z, got.status);
				return;
			end
			exp = awaited.pop_front();
			if (got.x !== exp.x || got.y !== exp.y || got.z !== exp.z ||
				got.status !== exp.status) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"ERROR: point mismatch exp x=%0d y=%0d z=%0d st=%0d,",
						" got x=%0d y=%0d z=%0d st=%0d"},
						exp.x, exp.y, exp.z, exp.status, got.x, got.y, got.z, got.status);
			end
		endfunction

		function int outstanding();
			return awaited.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WORD_W-1:0]    cfg_data;

	pbw_in_if  in_ch ();
	pbw_out_if out_ch ();

	pinhole_backproject_to_world u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ingress   (in_ch.sink),
		.egress    (out_ch.source)
	);

	world_point_board board;
	int  cycle_count;
	int  hold_cycles;   // a long receiver hold-off requested by the stimulus
	bit  steady;        // when set, neither side idles
	int  requests_sent;
	int  loads_sent;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// The watchdog ends a run that hangs, for example when the pipeline stops
	// delivering results.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d points still awaited",
				cycle_count, board.outstanding());
			$display("FAILURE");
			$finish;
		end
	end

	// Every egress handshake is checked at the rising edge.
	always @(posedge clk) begin
		world_pt_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.x = out_ch.world_x;
			got.y = out_ch.world_y;
			got.z = out_ch.world_z;
			got.status = out_ch.status;
			board.check_result(got);
		end
	end

	// The receiver stalls a random number of cycles before each result. A
	// pending hold-off request replaces one such stall with a long stretch, so
	// the pipeline fills and pushes back on ingress.
	initial begin
		int stall;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				stall = hold_cycles;
				hold_cycles = 0;
			end else begin
				stall = steady ? 0 : $urandom_range(0, MAX_GAP);
			end
			if (stall > 0) begin
				out_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ch.ready = 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	// Writes one camera register; called and returning at a falling edge.
	task automatic write_reg(cfg_idx_t idx, logic [WORD_W-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		board.set_reg(idx, val);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic write_camera(logic [WORD_W-1:0] fx, logic [WORD_W-1:0] fy,
		logic [WORD_W-1:0] ox, logic [WORD_W-1:0] oy);
		write_reg(CFG_INV_FX, fx);
		write_reg(CFG_INV_FY, fy);
		write_reg(CFG_OFF_X, ox);
		write_reg(CFG_OFF_Y, oy);
	endtask

	// Offers one request after a random gap and waits for it to be accepted.
	// Valid stays high from one request to the next when the gap is zero.
	task automatic send(request_t r);
		int gap;
		gap = steady ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.action = r.action;
		in_ch.pose_slot = r.slot;
		in_ch.pose_word = r.word;
		in_ch.pixel_u = r.u;
		in_ch.pixel_v = r.v;
		in_ch.inverse_depth = r.idep;
		in_ch.final_frame = r.fin;
		in_ch.valid = 1'b1;
		do @(posedge clk); while (!in_ch.ready);
		board.note_request(r);
		requests_sent++;
		if (r.action == ACT_LOAD) loads_sent++;
		@(negedge clk);
	endtask

	// Stops offering and waits until every awaited point has come back, then
	// lets the pipeline settle so a trailing pose write has landed as well.
	task automatic drain();
		in_ch.valid = 1'b0;
		while (board.outstanding() > 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Load and point requests carry random junk in the fields they ignore.
	function automatic request_t pose_load(int slot, logic [WORD_W-1:0] word);
		request_t r;
		r.action = ACT_LOAD;
		r.slot = SLOT_W'(slot);
		r.word = word;
		r.u = PIX_W'($urandom);
		r.v = PIX_W'($urandom);
		r.idep = IDEP_W'($urandom);
		r.fin = 1'($urandom);
		return r;
	endfunction

	function automatic request_t point(logic [PIX_W-1:0] u, logic [PIX_W-1:0] v,
		logic [IDEP_W-1:0] idep, logic fin);
		request_t r;
		r.action = ACT_POINT;
		r.slot = SLOT_W'($urandom);
		r.word = $urandom;
		r.u = u;
		r.v = v;
		r.idep = idep;
		r.fin = fin;
		return r;
	endfunction

	// A plausible pose: rotation entries within about +-1.0, translation within
	// a few hundred units. Now and then a word takes any 32-bit value.
	function automatic logic [WORD_W-1:0] pose_value(int slot);
		int sel;
		sel = $urandom_range(0, 19);
		if (sel == 0) return $urandom;
		if (sel == 1) return (slot < ROT_WORDS) ? 32'h7fffffff : 32'h80000000;
		if (slot < ROT_WORDS) return $urandom_range(0, 32'h80000000) - 32'h40000000;
		return $urandom_range(0, 32'h04000000) - 32'h02000000;
	endfunction

	// Mostly real depths up to sixteen units; the rest covers the full range.
	function automatic request_t random_point();
		logic [IDEP_W-1:0] idep;
		int sel;
		sel = $urandom_range(0, 39);
		if (sel == 0) idep = '0;
		else if (sel == 1) idep = 20'd1;
		else if (sel < 8) idep = IDEP_W'($urandom);
		else idep = IDEP_W'($urandom_range(20'h01000, 20'hfffff));
		return point(PIX_W'($urandom), PIX_W'($urandom), idep,
			($urandom_range(0, 19) != 0));
	endfunction

	task automatic load_full_pose();
		for (int s = 0; s < POSE_WORDS; s++) send(pose_load(s, pose_value(s)));
	endtask

	// One phase of random traffic: runs of points, some preceded by a full pose
	// or by a stray single-word write, including ignored slots.
	task automatic random_traffic(int count, bit with_hold);
		int sent;
		int sel;
		sent = 0;
		while (sent < count) begin
			steady = ($urandom_range(0, 5) == 0);
			sel = $urandom_range(0, 9);
			if (sel < 2) begin
				load_full_pose();
				sent += POSE_WORDS;
			end else if (sel == 2) begin
				send(pose_load($urandom_range(0, 15), $urandom));
				sent++;
			end
			if (with_hold && sent > count / 2) begin
				hold_cycles = 300;
				with_hold = 0;
			end
			repeat ($urandom_range(4, 30)) begin
				send(random_point());
				sent++;
			end
		end
		steady = 0;
	endtask

	initial begin
		board = new();
		board.clear_state();
		cycle_count = 0;
		hold_cycles = 0;
		steady = 0;
		requests_sent = 0;
		loads_sent = 0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.action = ACT_LOAD;
		in_ch.pose_slot = '0;
		in_ch.pose_word = '0;
		in_ch.pixel_u = '0;
		in_ch.pixel_v = '0;
		in_ch.inverse_depth = '0;
		in_ch.final_frame = 1'b0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part. A point straight after reset sees an all-zero pose
		// and zero camera registers.
		send(point(20'hfffff, 20'hfffff, 20'h10000, 1'b1));
		drain();
		write_camera(32'd8589934, 32'd8589934, 32'hf0000000, 32'hf4000000);
		// Identity rotation, zero translation, then a write to an unused slot
		// that must leave the pose alone.
		for (int s = 0; s < POSE_WORDS; s++)
			send(pose_load(s, (s == 0 || s == 4 || s == 8) ? 32'h40000000 : 32'h0));
		send(pose_load(15, 32'hffffffff));
		send(point(20'h0, 20'h0, 20'h10000, 1'b1));
		send(point(20'hfffff, 20'hfffff, 20'hfffff, 1'b1));
		send(point(20'h1234, 20'h0abc, 20'h0, 1'b1));
		// Non-final takes precedence over a zero inverse depth.
		send(point(20'h1234, 20'h0abc, 20'h0, 1'b0));
		send(point(20'h1234, 20'h0abc, 20'h08000, 1'b0));
		// Depth of 2^16 units drives every coordinate out of range.
		send(point(20'hfffff, 20'hfffff, 20'h1, 1'b1));
		send(pose_load(11, 32'h7fffffff));
		send(point(20'h0, 20'h0, 20'h10000, 1'b1));
		send(pose_load(11, 32'h80000000));
		send(point(20'h0, 20'h0, 20'h10000, 1'b1));
		drain();

		// Phase with typical camera constants; the long receiver hold-off
		// happens here while points keep coming.
		random_traffic(340, 1);
		drain();

		// Register extremes: largest inverse focal lengths and offsets.
		write_camera(32'hffffffff, 32'hffffffff, 32'h7fffffff, 32'h80000000);
		random_traffic(340, 0);
		drain();

		write_camera(32'h0, 32'h0, 32'h80000000, 32'h7fffffff);
		random_traffic(340, 0);
		drain();

		write_camera($urandom, $urandom, $urandom, $urandom);
		random_traffic(340, 0);
		drain();

		write_camera(32'd4294967, 32'd5368709, 32'hfc000000, 32'hfd000000);
		random_traffic(340, 0);
		drain();

		$display("Sent %0d requests (%0d pose writes), checked %0d world points",
			requests_sent, loads_sent, board.points_checked);
		$display("Covered six camera settings, with %0d mismatches", board.mismatches);
		if (board.mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
